// ----- hdl/tlwa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlwa_pkg
// Shared widths, constants, state and command types for the top-depth
// length-weighted average core.
// ----------------------------------------------------------------------------
package tlwa_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int DEPTH_W         = 32;
    localparam int LEN_W           = 20;
    localparam int ID_W            = 16;
    localparam int CFG_W           = 24;
    localparam int THR_W           = 21;
    localparam int SUM_W           = 22;
    localparam int PROD_W          = DEPTH_W + LEN_W;
    localparam int ACC_W           = DEPTH_W + SUM_W;
    localparam int DIVCNT_W        = $clog2(ACC_W + 1);
    localparam int NT_DIVISOR      = 10;
    localparam int LEN_RESET       = 1000;
    localparam int THR_RESET       = LEN_RESET / NT_DIVISOR;
    localparam int RECIP_W         = 32;
    localparam int RECIP_SHIFT     = 35;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [LEN_W-1:0]   len;
        logic [ID_W-1:0]    id;
    } entry_t;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_SRD, S_SEV, S_OVF, S_SHR, S_SHW, S_PRE, S_PRD,
        S_PAC, S_AFT, S_MINIT, S_MRD, S_MMUL, S_MADD, S_DINIT, S_DIV, S_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_SRD, OP_SEV, OP_OVF, OP_SHRD, OP_SHWR, OP_INSERT,
        OP_PINIT, OP_PRD, OP_PACC, OP_PEND, OP_MINIT, OP_MRD, OP_MMUL,
        OP_MADD, OP_DINIT, OP_DSTEP, OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic ins_ok;
        logic last;
        logic srch_valid;
        logic srch_more;
        logic drop;
        logic shift_more;
        logic pre_more;
        logic mul_more;
        logic div_last;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

// ----- hdl/tlwa_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlwa_ctrl
// Sequencer: walks search, shift, insert, prefix cut, accumulate and divide.
// ----------------------------------------------------------------------------
module tlwa_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire tlwa_pkg::status_t sts,
    output tlwa_pkg::cmd_t        cmd
);

    tlwa_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlwa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = tlwa_pkg::OP_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            tlwa_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = tlwa_pkg::OP_LOAD;
                    state_next = tlwa_pkg::S_CHECK;
                end
            end
            tlwa_pkg::S_CHECK:
            begin
                state_next = sts.ins_ok ? tlwa_pkg::S_SRD : tlwa_pkg::S_AFT;
            end
            tlwa_pkg::S_SRD:
            begin
                if (sts.srch_valid)
                begin
                    cmd.op     = tlwa_pkg::OP_SRD;
                    state_next = tlwa_pkg::S_SEV;
                end
                else
                begin
                    state_next = tlwa_pkg::S_OVF;
                end
            end
            tlwa_pkg::S_SEV:
            begin
                cmd.op     = tlwa_pkg::OP_SEV;
                state_next = sts.srch_more ? tlwa_pkg::S_SRD : tlwa_pkg::S_OVF;
            end
            tlwa_pkg::S_OVF:
            begin
                cmd.op     = tlwa_pkg::OP_OVF;
                state_next = tlwa_pkg::S_SHR;
            end
            tlwa_pkg::S_SHR:
            begin
                priority if (sts.drop)
                begin
                    state_next = tlwa_pkg::S_PRE;
                end
                else if (sts.shift_more)
                begin
                    cmd.op     = tlwa_pkg::OP_SHRD;
                    state_next = tlwa_pkg::S_SHW;
                end
                else
                begin
                    cmd.op     = tlwa_pkg::OP_INSERT;
                    state_next = tlwa_pkg::S_PRE;
                end
            end
            tlwa_pkg::S_SHW:
            begin
                cmd.op     = tlwa_pkg::OP_SHWR;
                state_next = tlwa_pkg::S_SHR;
            end
            tlwa_pkg::S_PRE:
            begin
                cmd.op     = tlwa_pkg::OP_PINIT;
                state_next = tlwa_pkg::S_PRD;
            end
            tlwa_pkg::S_PRD:
            begin
                if (sts.pre_more)
                begin
                    cmd.op     = tlwa_pkg::OP_PRD;
                    state_next = tlwa_pkg::S_PAC;
                end
                else
                begin
                    cmd.op     = tlwa_pkg::OP_PEND;
                    state_next = tlwa_pkg::S_AFT;
                end
            end
            tlwa_pkg::S_PAC:
            begin
                cmd.op     = tlwa_pkg::OP_PACC;
                state_next = tlwa_pkg::S_PRD;
            end
            tlwa_pkg::S_AFT:
            begin
                state_next = sts.last ? tlwa_pkg::S_MINIT : tlwa_pkg::S_IDLE;
            end
            tlwa_pkg::S_MINIT:
            begin
                cmd.op     = tlwa_pkg::OP_MINIT;
                state_next = tlwa_pkg::S_MRD;
            end
            tlwa_pkg::S_MRD:
            begin
                if (sts.mul_more)
                begin
                    cmd.op     = tlwa_pkg::OP_MRD;
                    state_next = tlwa_pkg::S_MMUL;
                end
                else
                begin
                    state_next = tlwa_pkg::S_DINIT;
                end
            end
            tlwa_pkg::S_MMUL:
            begin
                cmd.op     = tlwa_pkg::OP_MMUL;
                state_next = tlwa_pkg::S_MADD;
            end
            tlwa_pkg::S_MADD:
            begin
                cmd.op     = tlwa_pkg::OP_MADD;
                state_next = tlwa_pkg::S_MRD;
            end
            tlwa_pkg::S_DINIT:
            begin
                cmd.op     = tlwa_pkg::OP_DINIT;
                state_next = tlwa_pkg::S_DIV;
            end
            tlwa_pkg::S_DIV:
            begin
                cmd.op     = tlwa_pkg::OP_DSTEP;
                state_next = sts.div_last ? tlwa_pkg::S_OUT : tlwa_pkg::S_DIV;
            end
            tlwa_pkg::S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = tlwa_pkg::OP_OUT;
                    state_next = tlwa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tlwa_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/tlwa_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlwa_dp
// Datapath: entry memory, search/shift/prefix counters, multiply-accumulate,
// bit-serial divider, threshold register and output register.
// ----------------------------------------------------------------------------
module tlwa_dp #(
    parameter int MAX_ENTRIES = tlwa_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tlwa_pkg::CFG_W-1:0]    longest_transcript_len,
    input  wire logic [tlwa_pkg::DEPTH_W-1:0]  exon_depth,
    input  wire logic [tlwa_pkg::LEN_W-1:0]    exon_length,
    input  wire logic [tlwa_pkg::ID_W-1:0]     exon_id,
    input  wire logic                          skip_exon,
    input  wire logic                          last_exon,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [tlwa_pkg::DEPTH_W-1:0]       average_depth,
    output logic                               empty_list,
    output logic                               list_overflow,
    input  wire tlwa_pkg::cmd_t                cmd,
    output tlwa_pkg::status_t                  sts
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);
    localparam logic [CW-1:0] CNT_TOP = CW'(MAX_ENTRIES - 1);

    tlwa_pkg::entry_t mem [MAX_ENTRIES];
    tlwa_pkg::entry_t rdata_reg;
    tlwa_pkg::entry_t new_entry;
    logic [AW-1:0]    raddr;
    logic [AW-1:0]    waddr;
    tlwa_pkg::entry_t wdata;
    logic             we;

    logic [tlwa_pkg::DEPTH_W-1:0] dep_reg;
    logic [tlwa_pkg::LEN_W-1:0]   len_reg;
    logic [tlwa_pkg::ID_W-1:0]    id_reg;
    logic                         skip_reg;
    logic                         last_reg;

    logic [tlwa_pkg::THR_W-1:0]   thr_reg;
    logic [CW-1:0]                count_reg;
    logic [tlwa_pkg::SUM_W-1:0]   kept_reg;
    logic [tlwa_pkg::DEPTH_W-1:0] lowest_reg;
    logic                         ovf_reg;

    logic [CW-1:0]                pos_reg;
    logic [CW-1:0]                k_reg;
    logic [tlwa_pkg::SUM_W-1:0]   sum_reg;
    logic [tlwa_pkg::DEPTH_W-1:0] lastd_reg;
    logic [tlwa_pkg::PROD_W-1:0]  prod_reg;
    logic [tlwa_pkg::ACC_W-1:0]   acc_reg;
    logic [tlwa_pkg::ACC_W-1:0]   quo_reg;
    logic [tlwa_pkg::SUM_W-1:0]   rem_reg;
    logic [tlwa_pkg::DIVCNT_W-1:0] dcnt_reg;

    logic                         out_valid_reg;
    logic [tlwa_pkg::DEPTH_W-1:0] avg_reg;
    logic                         empty_reg;
    logic                         ovf_out_reg;

    logic [tlwa_pkg::CFG_W+tlwa_pkg::RECIP_W-1:0] thr_prod;
    logic [tlwa_pkg::SUM_W:0]     trial;
    logic                         fits;
    logic                         bump;

    assign cfg_ready = 1'b1;
    assign thr_prod  = {{tlwa_pkg::RECIP_W{1'b0}}, longest_transcript_len}
                     * {{tlwa_pkg::CFG_W{1'b0}}, tlwa_pkg::RECIP_TEN};

    assign new_entry = '{depth: dep_reg, len: len_reg, id: id_reg};
    assign trial     = {rem_reg, quo_reg[tlwa_pkg::ACC_W-1]};
    assign fits      = trial >= {1'b0, kept_reg};
    assign bump      = (rdata_reg.depth == dep_reg)
                     && ((rdata_reg.len > len_reg)
                         || ((rdata_reg.len == len_reg) && (rdata_reg.id < id_reg)));

    always_comb
    begin
        raddr = pos_reg[AW-1:0];
        we    = 1'b0;
        waddr = k_reg[AW-1:0];
        wdata = rdata_reg;
        unique case (cmd.op)
            tlwa_pkg::OP_SHRD:
            begin
                raddr = AW'(k_reg - CW'(1));
            end
            tlwa_pkg::OP_PRD, tlwa_pkg::OP_MRD:
            begin
                raddr = k_reg[AW-1:0];
            end
            tlwa_pkg::OP_SHWR:
            begin
                we = 1'b1;
            end
            tlwa_pkg::OP_INSERT:
            begin
                we    = 1'b1;
                waddr = pos_reg[AW-1:0];
                wdata = new_entry;
            end
            default:
            begin
                raddr = pos_reg[AW-1:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= tlwa_pkg::THR_W'(tlwa_pkg::THR_RESET);
            count_reg     <= '0;
            kept_reg      <= '0;
            lowest_reg    <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                thr_reg <= thr_prod[tlwa_pkg::RECIP_SHIFT+tlwa_pkg::THR_W-1:
                                    tlwa_pkg::RECIP_SHIFT];
            end
            out_valid_reg <= (cmd.op == tlwa_pkg::OP_OUT) || (out_valid_reg && !out_ready);
            unique case (cmd.op)
                tlwa_pkg::OP_OVF:
                begin
                    if (count_reg == CNT_MAX)
                    begin
                        ovf_reg <= 1'b1;
                        if (pos_reg != CNT_MAX)
                        begin
                            count_reg <= CNT_TOP;
                        end
                    end
                end
                tlwa_pkg::OP_INSERT:
                begin
                    count_reg <= count_reg + CW'(1);
                end
                tlwa_pkg::OP_PEND:
                begin
                    count_reg  <= k_reg;
                    kept_reg   <= sum_reg;
                    lowest_reg <= (k_reg != '0) ? lastd_reg : '0;
                end
                tlwa_pkg::OP_OUT:
                begin
                    count_reg     <= '0;
                    kept_reg      <= '0;
                    lowest_reg    <= '0;
                    ovf_reg       <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            tlwa_pkg::OP_LOAD:
            begin
                dep_reg  <= exon_depth;
                len_reg  <= exon_length;
                id_reg   <= exon_id;
                skip_reg <= skip_exon;
                last_reg <= last_exon;
                pos_reg  <= '0;
            end
            tlwa_pkg::OP_SEV:
            begin
                if ((rdata_reg.depth > dep_reg) || bump)
                begin
                    pos_reg <= pos_reg + CW'(1);
                end
            end
            tlwa_pkg::OP_OVF:
            begin
                k_reg <= (count_reg == CNT_MAX) ? CNT_TOP : count_reg;
            end
            tlwa_pkg::OP_SHWR:
            begin
                k_reg <= k_reg - CW'(1);
            end
            tlwa_pkg::OP_PINIT, tlwa_pkg::OP_MINIT:
            begin
                k_reg   <= '0;
                sum_reg <= '0;
                acc_reg <= '0;
            end
            tlwa_pkg::OP_PACC:
            begin
                sum_reg   <= sum_reg + tlwa_pkg::SUM_W'(rdata_reg.len);
                lastd_reg <= rdata_reg.depth;
                k_reg     <= k_reg + CW'(1);
            end
            tlwa_pkg::OP_MMUL:
            begin
                prod_reg <= rdata_reg.depth * tlwa_pkg::PROD_W'(rdata_reg.len);
                k_reg    <= k_reg + CW'(1);
            end
            tlwa_pkg::OP_MADD:
            begin
                acc_reg <= acc_reg + tlwa_pkg::ACC_W'(prod_reg);
            end
            tlwa_pkg::OP_DINIT:
            begin
                quo_reg  <= acc_reg;
                rem_reg  <= '0;
                dcnt_reg <= tlwa_pkg::DIVCNT_W'(tlwa_pkg::ACC_W);
            end
            tlwa_pkg::OP_DSTEP:
            begin
                rem_reg  <= fits ? tlwa_pkg::SUM_W'(trial - {1'b0, kept_reg})
                                 : tlwa_pkg::SUM_W'(trial);
                quo_reg  <= {quo_reg[tlwa_pkg::ACC_W-2:0], fits};
                dcnt_reg <= dcnt_reg - tlwa_pkg::DIVCNT_W'(1);
            end
            tlwa_pkg::OP_OUT:
            begin
                avg_reg     <= (kept_reg == '0) ? '0 : quo_reg[tlwa_pkg::DEPTH_W-1:0];
                empty_reg   <= (count_reg == '0);
                ovf_out_reg <= ovf_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        sts.ins_ok     = !skip_reg
                       && ((kept_reg < tlwa_pkg::SUM_W'(thr_reg)) || (dep_reg >= lowest_reg));
        sts.last       = last_reg;
        sts.srch_valid = pos_reg < count_reg;
        sts.srch_more  = rdata_reg.depth > dep_reg;
        sts.drop       = pos_reg == CNT_MAX;
        sts.shift_more = k_reg > pos_reg;
        sts.pre_more   = (sum_reg < tlwa_pkg::SUM_W'(thr_reg)) && (k_reg < count_reg);
        sts.mul_more   = k_reg < count_reg;
        sts.div_last   = dcnt_reg == tlwa_pkg::DIVCNT_W'(1);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign average_depth = avg_reg;
    assign empty_list    = empty_reg;
    assign list_overflow = ovf_out_reg;

endmodule
`default_nettype wire

// ----- hdl/top_depth_length_weighted_average_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// top_depth_length_weighted_average_core
// Keeps a depth-sorted exon list cut to a nucleotide threshold and returns
// the length-weighted mean depth on the cell's last exon.
//
//  channel  handshake            payload
//  in       in_valid/in_ready    exon_depth exon_length exon_id skip_exon last_exon
//  out      out_valid/out_ready  average_depth empty_list list_overflow
//  cfg      cfg_valid/cfg_ready  longest_transcript_len
//
// One item per beat, one at a time; entry memory has a single read port.
// Insertion: search, shift of the entries below the slot, insert, prefix cut.
// Last exon adds a multiply-accumulate pass over kept entries and ACC_W(54) divider steps.
// Output register lets the next beat enter while a result waits.
// Reset clears control state only; the entry memory needs no clearing.
// ----------------------------------------------------------------------------
module top_depth_length_weighted_average_core #(
    parameter int MAX_ENTRIES = tlwa_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tlwa_pkg::CFG_W-1:0]    longest_transcript_len,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [tlwa_pkg::DEPTH_W-1:0]  exon_depth,
    input  wire logic [tlwa_pkg::LEN_W-1:0]    exon_length,
    input  wire logic [tlwa_pkg::ID_W-1:0]     exon_id,
    input  wire logic                          skip_exon,
    input  wire logic                          last_exon,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [tlwa_pkg::DEPTH_W-1:0]       average_depth,
    output logic                               empty_list,
    output logic                               list_overflow
);

    tlwa_pkg::cmd_t    cmd;
    tlwa_pkg::status_t sts;

    tlwa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tlwa_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .longest_transcript_len (longest_transcript_len),
        .exon_depth             (exon_depth),
        .exon_length            (exon_length),
        .exon_id                (exon_id),
        .skip_exon              (skip_exon),
        .last_exon              (last_exon),
        .out_valid              (out_valid),
        .out_ready              (out_ready),
        .average_depth          (average_depth),
        .empty_list             (empty_list),
        .list_overflow          (list_overflow),
        .cmd                    (cmd),
        .sts                    (sts)
    );

endmodule
`default_nettype wire

// ----- hdl/tlwa_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlwa_checker
// Port-level checks for the top-depth length-weighted average core.
// ----------------------------------------------------------------------------
module tlwa_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [tlwa_pkg::DEPTH_W-1:0] average_depth,
    input wire logic                         empty_list
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input beat dropped before accept");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(average_depth))
        else $error("stalled result changed");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_list |-> average_depth == '0)
        else $error("empty list with nonzero average");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accepted beat");

endmodule

bind top_depth_length_weighted_average_core tlwa_checker u_tlwa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .average_depth (average_depth),
    .empty_list    (empty_list)
);
`default_nettype wire

// ----- tb/sv/top_depth_length_weighted_average_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_depth_length_weighted_average_core_tb
// Drives cells of exons through the core under several transcript lengths
// and checks each cell's weighted mean depth and flags against a local
// model of the sorted, threshold-cut exon list.
// ----------------------------------------------------------------------------
module top_depth_length_weighted_average_core_tb;

    localparam int DEPTH_W    = tlwa_pkg::DEPTH_W;
    localparam int LEN_W      = tlwa_pkg::LEN_W;
    localparam int ID_W       = tlwa_pkg::ID_W;
    localparam int CFG_W      = tlwa_pkg::CFG_W;
    localparam int NT_DIVISOR = tlwa_pkg::NT_DIVISOR;
    localparam int LEN_RESET  = tlwa_pkg::LEN_RESET;
    localparam int NLIST    = tlwa_pkg::MAX_ENTRIES_DEF;
    localparam int STALL_LIM = 20000;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [LEN_W-1:0]   len;
        logic [ID_W-1:0]    id;
        logic               skip;
        logic               last;
    } exon_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] avg;
        logic               empty;
        logic               ovf;
    } cell_result_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_W-1:0] longest_transcript_len;
    logic in_valid;
    logic in_ready;
    logic [DEPTH_W-1:0] exon_depth;
    logic [LEN_W-1:0] exon_length;
    logic [ID_W-1:0] exon_id;
    logic skip_exon;
    logic last_exon;
    logic out_valid;
    logic out_ready;
    logic [DEPTH_W-1:0] average_depth;
    logic empty_list;
    logic list_overflow;

    top_depth_length_weighted_average_core DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .longest_transcript_len(longest_transcript_len),
        .in_valid(in_valid), .in_ready(in_ready),
        .exon_depth(exon_depth), .exon_length(exon_length), .exon_id(exon_id),
        .skip_exon(skip_exon), .last_exon(last_exon),
        .out_valid(out_valid), .out_ready(out_ready),
        .average_depth(average_depth), .empty_list(empty_list),
        .list_overflow(list_overflow)
    );

    exon_t        exon_q[$];
    cell_result_t cell_avg_q[$];
    int           errors = 0;
    bit           calm = 0;
    bit           in_beat = 0;
    int           quiet_cycles = 0;

    // cell list model
    logic [DEPTH_W-1:0] m_depth[NLIST];
    logic [LEN_W-1:0]   m_len[NLIST];
    logic [ID_W-1:0]    m_id[NLIST];
    int                 m_count = 0;
    logic [31:0]        m_kept = 0;
    logic [DEPTH_W-1:0] m_lowest = 0;
    bit                 m_ovf = 0;
    logic [CFG_W-1:0]   m_trlen = CFG_W'(LEN_RESET);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    task automatic enqueue_exon(input exon_t e);
        exon_q.insert(exon_q.size(), e);
    endtask

    task automatic list_insert(input exon_t e, input logic [31:0] thr);
        int pos;
        int k;
        logic [31:0] sum;
        pos = 0;
        while (pos < m_count && m_depth[pos] > e.depth)
            pos++;
        if (pos < m_count && m_depth[pos] == e.depth)
        begin
            if (m_len[pos] > e.len)
                pos++;
            else if (m_len[pos] == e.len && m_id[pos] < e.id)
                pos++;
        end
        if (m_count >= NLIST)
        begin
            m_ovf = 1;
            m_count = NLIST - 1;
            if (pos > m_count)
                pos = NLIST;
        end
        if (pos < NLIST)
        begin
            for (k = m_count; k > pos; k--)
            begin
                m_depth[k] = m_depth[k-1];
                m_len[k] = m_len[k-1];
                m_id[k] = m_id[k-1];
            end
            m_depth[pos] = e.depth;
            m_len[pos] = e.len;
            m_id[pos] = e.id;
            m_count++;
        end
        else
            m_count = NLIST;
        sum = 0;
        k = 0;
        while (sum < thr && k < m_count)
        begin
            sum += 32'(m_len[k]);
            k++;
        end
        m_count = k;
        m_kept = sum;
        m_lowest = (k > 0) ? m_depth[k-1] : '0;
    endtask

    task automatic exon_accepted(input exon_t e);
        logic [31:0] thr;
        logic [63:0] acc;
        cell_result_t r;
        thr = 32'(m_trlen) / NT_DIVISOR;
        if (!e.skip && (m_kept < thr || e.depth >= m_lowest))
            list_insert(e, thr);
        if (e.last)
        begin
            acc = 0;
            for (int k = 0; k < m_count; k++)
                acc += 64'(m_depth[k]) * 64'(m_len[k]);
            r.avg = (m_kept != 0) ? DEPTH_W'(acc / 64'(m_kept)) : '0;
            r.empty = (m_count == 0);
            r.ovf = m_ovf;
            cell_avg_q.insert(cell_avg_q.size(), r);
            m_count = 0;
            m_kept = 0;
            m_lowest = 0;
            m_ovf = 0;
        end
    endtask

    // sample side
    always @(posedge clk)
    begin
        cell_result_t r;
        in_beat = rst_n && in_valid && in_ready;
        if (in_beat)
            exon_accepted({exon_depth, exon_length, exon_id, skip_exon, last_exon});
        if (rst_n && cfg_valid && cfg_ready)
            m_trlen = longest_transcript_len;
        if (rst_n && out_valid && out_ready)
        begin
            if (cell_avg_q.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                r = cell_avg_q.pop_front();
                if (average_depth !== r.avg)
                begin
                    $error("average_depth exp %0d got %0d", r.avg, average_depth);
                    errors++;
                end
                if (empty_list !== r.empty)
                begin
                    $error("empty_list exp %0d got %0d", r.empty, empty_list);
                    errors++;
                end
                if (list_overflow !== r.ovf)
                begin
                    $error("list_overflow exp %0d got %0d", r.ovf, list_overflow);
                    errors++;
                end
            end
        end
        if (in_beat || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIM)
        begin
            $display("top_depth_length_weighted_average_core verification failed");
            $finish;
        end
    end

    // drive side
    always @(negedge clk)
    begin
        exon_t e;
        if (rst_n)
        begin
            out_ready <= calm || ($urandom_range(99) >= 29);
            if (!in_valid || in_beat)
            begin
                if (exon_q.size() != 0 && (calm || $urandom_range(99) >= 29))
                begin
                    e = exon_q.pop_front();
                    in_valid <= 1'b1;
                    exon_depth <= e.depth;
                    exon_length <= e.len;
                    exon_id <= e.id;
                    skip_exon <= e.skip;
                    last_exon <= e.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    function automatic exon_t mk(input logic [31:0] d, input logic [19:0] l,
                                 input logic [15:0] i, input bit s, input bit t);
        exon_t e;
        e.depth = d;
        e.len = l;
        e.id = i;
        e.skip = s;
        e.last = t;
        return e;
    endfunction

    task automatic add_cell(input int n, input bit short_exons);
        logic [31:0] d;
        logic [19:0] l;
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(3))
                0: d = $urandom;
                1: d = 32'($urandom_range(7));
                2: d = {4'($urandom_range(3)), 28'h0};
                default: d = 32'($urandom_range(4096 * 64));
            endcase
            if (short_exons)
                l = 20'($urandom_range(1, 40));
            else if ($urandom_range(9) == 0)
                l = 20'($urandom_range(1, 20'hFFFFF));
            else if ($urandom_range(4) == 0)
                l = 20'($urandom_range(1, 4));
            else
                l = 20'($urandom_range(1, 300));
            enqueue_exon(mk(d, l, 16'($urandom), $urandom_range(15) == 0, k == n - 1));
        end
    endtask

    task automatic set_trlen(input logic [CFG_W-1:0] v);
        wait (exon_q.size() == 0 && cell_avg_q.size() == 0 && !in_valid);
        repeat (400) @(negedge clk);
        cfg_valid <= 1'b1;
        longest_transcript_len <= v;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [CFG_W-1:0] trlen_set[6];
        int sent;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        longest_transcript_len = '0;
        in_valid = 1'b0;
        exon_depth = '0;
        exon_length = '0;
        exon_id = '0;
        skip_exon = 1'b0;
        last_exon = 1'b0;
        out_ready = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, reset transcript length: extremes, ties, skips
        enqueue_exon(mk(32'hFFFF_FFFF, 20'hFFFFF, 16'hFFFF, 1'b0, 1'b0));
        enqueue_exon(mk(32'h0, 20'd1, 16'h0, 1'b0, 1'b0));
        enqueue_exon(mk(32'h1000, 20'd30, 16'd5, 1'b0, 1'b0));
        enqueue_exon(mk(32'h1000, 20'd50, 16'd5, 1'b0, 1'b0));
        enqueue_exon(mk(32'h1000, 20'd30, 16'd2, 1'b0, 1'b0));
        enqueue_exon(mk(32'h1000, 20'd30, 16'd9, 1'b0, 1'b0));
        enqueue_exon(mk(32'h1000, 20'd10, 16'd1, 1'b1, 1'b1));
        enqueue_exon(mk(32'h5, 20'd7, 16'd1, 1'b1, 1'b1));
        enqueue_exon(mk(32'h2000, 20'd40, 16'd3, 1'b0, 1'b0));
        enqueue_exon(mk(32'h3000, 20'd40, 16'd4, 1'b0, 1'b0));
        enqueue_exon(mk(32'h1000, 20'd40, 16'd6, 1'b0, 1'b0));
        enqueue_exon(mk(32'h4000, 20'd200, 16'd7, 1'b0, 1'b0));
        enqueue_exon(mk(32'h0, 20'd1, 16'd8, 1'b0, 1'b1));
        enqueue_exon(mk(32'h7FFF_FFFF, 20'd99, 16'h8000, 1'b0, 1'b1));

        set_trlen(CFG_W'(10));
        for (int k = 0; k < 6; k++)
            enqueue_exon(mk($urandom, 20'($urandom_range(1, 3)), 16'($urandom), 1'b0,
                            k == 5));

        // overflow: long cells of short exons under the largest threshold
        set_trlen(CFG_W'(24'hFFFFFF));
        for (int c = 0; c < 3; c++)
            add_cell($urandom_range(66, 80), 1'b1);

        trlen_set[0] = 24'd1000;
        trlen_set[1] = 24'd10;
        trlen_set[2] = 24'hFFFFFF;
        trlen_set[3] = CFG_W'($urandom_range(10, 5000));
        trlen_set[4] = CFG_W'($urandom_range(10, 24'hFFFFFF));
        trlen_set[5] = 24'd3000;
        for (int p = 0; p < 6; p++)
        begin
            set_trlen(trlen_set[p]);
            calm = (p == 2);
            sent = 0;
            while (sent < 122)
            begin
                int n;
                n = ($urandom_range(19) == 0) ? int'($urandom_range(60, 72)) :
                    int'($urandom_range(1, 16));
                add_cell(n, p == 2 && n > 50);
                sent += n;
            end
        end

        wait (exon_q.size() == 0 && cell_avg_q.size() == 0 && !in_valid);
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("top_depth_length_weighted_average_core verification clean");
        else
            $display("top_depth_length_weighted_average_core verification failed");
        $finish;
    end
endmodule
